[design/rpip_pkg.sv]
// Shared types and codes for the radix-prefixed integer parser.
`timescale 1ns / 1ps
package rpip_pkg;

	typedef logic [2:0] phase_t;
	typedef logic [1:0] radix_t;
	typedef logic [1:0] status_t;

	localparam phase_t PH_IDLE   = 3'd0;
	localparam phase_t PH_SIGN   = 3'd1;
	localparam phase_t PH_ZERO   = 3'd2;
	localparam phase_t PH_PREFIX = 3'd3;
	localparam phase_t PH_DIGITS = 3'd4;

	localparam radix_t RADIX_DEC = 2'd0;
	localparam radix_t RADIX_BIN = 2'd1;
	localparam radix_t RADIX_HEX = 2'd2;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD_DEC = 2'd1;
	localparam status_t ST_BAD_BIN = 2'd2;
	localparam status_t ST_BAD_HEX = 2'd3;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Control part of the parser state plus the result flags of one step.
	typedef struct packed {
		logic    emit;
		status_t status;
		logic    neg;
		radix_t  radix;
		phase_t  phase;
	} step_ctl_t;

endpackage

[design/radix_prefixed_integer_parser_core.sv]
// Top level of the radix-prefixed integer parser: input register, step logic, result register.
// A token's value is loaded into the result register when its terminator, held in the input register, advances.
// Throughput: one character per cycle; ready drops only while a result waits
// in the result register and the consumer stalls.
// Reset (arst_n low, asynchronous): both stages empty, parser idle in decimal
// with a zero accumulator and no sign seen.
`timescale 1ns / 1ps
module radix_prefixed_integer_parser_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        token_start,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [31:0] value,
	output rpip_pkg::status_t  status
);
	import rpip_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       start_s1;

	// Parser state
	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	radix_t                radix_q;
	phase_t                phase_q;

	// Result register
	logic               res_valid_q;
	logic signed [31:0] value_q;
	status_t            status_q;

	logic [VALUE_BITS-1:0] acc_next;
	logic [VALUE_BITS-1:0] emit_value;
	step_ctl_t             ctl;
	logic                  advance;

	// Advance the registered character whenever the result slot is free or draining;
	// hold every character, whether or not it yields a result, while a result waits.
	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign char_ready = !valid_s1 || advance;

	rpip_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.char_code  (char_s1),
		.token_start(start_s1),
		.acc        (acc_q),
		.neg        (neg_q),
		.radix      (radix_q),
		.phase      (phase_q),
		.acc_next   (acc_next),
		.emit_value (emit_value),
		.ctl        (ctl)
	);

	// Capture an accepted item; hold it until the step logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1  <= char_code;
			start_s1 <= token_start;
		end
	end

	// Commit the new parser state when the registered character advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			radix_q <= RADIX_DEC;
			phase_q <= PH_IDLE;
		end else if (advance) begin
			acc_q   <= acc_next;
			neg_q   <= ctl.neg;
			radix_q <= ctl.radix;
			phase_q <= ctl.phase;
		end
	end

	// Load a finished result; drop it once the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Sign-extend or truncate the accumulator width to the 32-bit value field
	always_ff @(posedge clk) begin
		if (advance && ctl.emit) begin
			value_q  <= 32'($signed(emit_value));
			status_q <= ctl.status;
		end
	end

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign status       = status_q;

endmodule

[design/rpip_step.sv]
// Combinational next-state and result logic for one character.
`timescale 1ns / 1ps
module rpip_step #(
	parameter int VALUE_BITS = 32
) (
	input  logic [7:0]             char_code,
	input  logic                   token_start,
	input  logic [VALUE_BITS-1:0]  acc,
	input  logic                   neg,
	input  rpip_pkg::radix_t       radix,
	input  rpip_pkg::phase_t       phase,
	output logic [VALUE_BITS-1:0]  acc_next,
	output logic [VALUE_BITS-1:0]  emit_value,
	output rpip_pkg::step_ctl_t    ctl
);
	import rpip_pkg::*;

	logic [VALUE_BITS-1:0] a;
	logic                  n;
	radix_t                r;
	phase_t                p;
	logic                  run_digits;
	logic                  is_term;
	logic                  dig_ok;
	logic [3:0]            dig;

	assign is_term = (char_code == CH_NUL) || (char_code == CH_SPACE) ||
		(char_code == CH_TAB) || (char_code == CH_CR) || (char_code == CH_LF);

	always_comb begin
		a          = acc;
		n          = neg;
		r          = radix;
		p          = phase;
		run_digits = 1'b0;
		ctl        = '0;
		emit_value = '0;
		dig_ok     = 1'b0;
		dig        = 4'd0;

		if (token_start) begin
			a = '0;
			n = 1'b0;
			r = RADIX_DEC;
			p = PH_SIGN;
		end

		if (token_start && char_code == CH_MINUS) begin
			n = 1'b1;
		end else begin
			unique case (p)
				PH_SIGN: begin
					if (char_code == CH_ZERO) p = PH_ZERO;
					else run_digits = 1'b1;
				end
				PH_ZERO: begin
					if (char_code == CH_LC_B) begin
						r = RADIX_BIN;
						p = PH_PREFIX;
					end else if (char_code == CH_LC_X) begin
						r = RADIX_HEX;
						p = PH_PREFIX;
					end else begin
						run_digits = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (!n && char_code == CH_MINUS) begin
						n = 1'b1;
						p = PH_DIGITS;
					end else begin
						run_digits = 1'b1;
					end
				end
				PH_DIGITS: run_digits = 1'b1;
				default:   p = PH_IDLE;
			endcase
		end

		// Digit decode in the current radix
		if (r == RADIX_BIN) begin
			dig_ok = (char_code == CH_ZERO) || (char_code == CH_ONE);
			dig    = char_code[3:0];
		end else if (r == RADIX_HEX) begin
			if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
				dig_ok = 1'b1;
				dig    = char_code[3:0];
			end else if (char_code >= CH_UC_A && char_code <= CH_UC_F) begin
				dig_ok = 1'b1;
				dig    = 4'(char_code - CH_UC_A + 8'd10);
			end else if (char_code >= CH_LC_A && char_code <= CH_LC_F) begin
				dig_ok = 1'b1;
				dig    = 4'(char_code - CH_LC_A + 8'd10);
			end
		end else begin
			dig_ok = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
			dig    = char_code[3:0];
		end

		if (run_digits) begin
			if (is_term) begin
				ctl.emit   = 1'b1;
				ctl.status = ST_OK;
				emit_value = n ? (~a + 1'b1) : a;
				p          = PH_IDLE;
			end else if (!dig_ok) begin
				ctl.emit   = 1'b1;
				ctl.status = status_t'(r + 2'd1);
				p          = PH_IDLE;
			end else begin
				if (r == RADIX_BIN)
					a = (a << 1) | VALUE_BITS'(dig);
				else if (r == RADIX_HEX)
					a = (a << 4) | VALUE_BITS'(dig);
				else
					a = (a << 3) + (a << 1) + VALUE_BITS'(dig);
				p = PH_DIGITS;
			end
		end

		ctl.neg   = n;
		ctl.radix = r;
		ctl.phase = p;
		acc_next  = a;
	end

endmodule

[tb/tb_radix_prefixed_integer_parser_core.sv]
// Self-checking testbench for the radix-prefixed integer parser core.
`timescale 1ns / 1ps
module tb_radix_prefixed_integer_parser_core;
	import rpip_pkg::*;

	// One parsed token as the block reports it.
	typedef struct {
		logic signed [31:0] value;
		status_t            status;
	} token_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_ready;
	logic [7:0]         char_code = CH_NUL;
	logic               token_start = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] value;
	status_t            status;

	radix_prefixed_integer_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.token_start  (token_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser state mirrored in the testbench.
	logic [31:0] acc_value;
	logic        minus_seen;
	radix_t      cur_radix;
	phase_t      cur_phase;

	token_result_t pending_tokens[$];
	int            fail_count = 0;
	int            token_chars = 0;
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;

	// Finish a token on a terminator, fold in a digit, or flag a bad character.
	// Return 1 when the character produces a result.
	function automatic bit fold_char(input logic [7:0] c, output token_result_t res);
		int          digit;
		logic [31:0] base;
		res = '{value: '0, status: ST_OK};
		if (c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			res.value = minus_seen ? 32'd0 - acc_value : acc_value;
			cur_phase = PH_IDLE;
			return 1'b1;
		end
		digit = -1;
		case (cur_radix)
			RADIX_BIN: begin
				if (c == CH_ZERO || c == CH_ONE)
					digit = c - CH_ZERO;
			end
			RADIX_HEX: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					digit = c - CH_ZERO;
				else if (c >= CH_UC_A && c <= CH_UC_F)
					digit = c - CH_UC_A + 10;
				else if (c >= CH_LC_A && c <= CH_LC_F)
					digit = c - CH_LC_A + 10;
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					digit = c - CH_ZERO;
			end
		endcase
		if (digit < 0) begin
			case (cur_radix)
				RADIX_BIN: res.status = ST_BAD_BIN;
				RADIX_HEX: res.status = ST_BAD_HEX;
				default:   res.status = ST_BAD_DEC;
			endcase
			cur_phase = PH_IDLE;
			return 1'b1;
		end
		base = (cur_radix == RADIX_BIN) ? 32'd2 : (cur_radix == RADIX_HEX) ? 32'd16 : 32'd10;
		// Wrap silently at 32 bits.
		acc_value = acc_value * base + 32'(digit);
		cur_phase = PH_DIGITS;
		return 1'b0;
	endfunction

	// Advance the mirrored parser by one accepted character.
	function automatic bit parse_char(input logic [7:0] c, input logic start,
			output token_result_t res);
		res = '{value: '0, status: ST_OK};
		if (start) begin
			// Drop whatever token was open and restart here.
			acc_value  = '0;
			minus_seen = 1'b0;
			cur_radix  = RADIX_DEC;
			cur_phase  = PH_SIGN;
			if (c == CH_MINUS) begin
				minus_seen = 1'b1;
				return 1'b0;
			end
		end
		case (cur_phase)
			PH_SIGN: begin
				if (c == CH_ZERO) begin
					cur_phase = PH_ZERO;
					return 1'b0;
				end
			end
			PH_ZERO: begin
				// Only lower-case prefix letters switch the radix.
				if (c == CH_LC_B || c == CH_LC_X) begin
					cur_radix = (c == CH_LC_B) ? RADIX_BIN : RADIX_HEX;
					cur_phase = PH_PREFIX;
					return 1'b0;
				end
			end
			PH_PREFIX: begin
				// A sign may follow the prefix if none led the token.
				if (!minus_seen && c == CH_MINUS) begin
					minus_seen = 1'b1;
					cur_phase  = PH_DIGITS;
					return 1'b0;
				end
			end
			PH_DIGITS: ;
			default: begin
				// Idle: ignore everything until the next token start.
				cur_phase = PH_IDLE;
				return 1'b0;
			end
		endcase
		return fold_char(c, res);
	endfunction

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	// Offer one item, with random idle cycles first, and hold it until accepted.
	task automatic send_char(input logic [7:0] c, input logic start);
		token_result_t res;
		while ($urandom_range(99) < send_gap_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid  <= 1'b1;
		char_code   <= c;
		token_start <= start;
		do
			@(posedge clk);
		while (!char_ready);
		if (parse_char(c, start, res))
			pending_tokens.push_back(res);
	endtask

	// Hold off the sender until every pending result has come out.
	task automatic wait_drain();
		char_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == 0);
	endtask

	// Receiver: check each accepted result and stall at random.
	always @(posedge clk) begin
		token_result_t want;
		if (result_valid && result_ready) begin
			if (pending_tokens.size() == 0) begin
				report_failure($sformatf("unexpected result value=%0d status=%0d",
					value, status));
			end else begin
				want = pending_tokens.pop_front();
				if (value !== want.value || status !== want.status)
					report_failure($sformatf("expected value=%0d status=%0d, got value=%0d status=%0d",
						want.value, want.status, value, status));
			end
		end
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Characters while idle are dropped; a new start abandons an open token.
	task automatic test_ignored_and_restart();
		send_char("Z", 1'b0);
		send_char("1", 1'b1);
		send_char("2", 1'b0);
		send_char("7", 1'b1);
		send_char(CH_SPACE, 1'b0);
		wait_drain();
	endtask

	// A terminator straight after the start or the sign gives zero.
	task automatic test_empty_tokens();
		send_char(CH_SPACE, 1'b1);
		send_char(CH_MINUS, 1'b1);
		send_char(CH_NUL, 1'b0);
		wait_drain();
	endtask

	// Sign after a prefix, mixed-case hex, sign before a binary prefix.
	task automatic test_prefixes_and_signs();
		send_string("0x-fF");
		send_char(CH_TAB, 1'b0);
		send_string("-0b1");
		send_char(CH_LF, 1'b0);
		wait_drain();
	endtask

	// Upper-case prefix letter, doubled sign, top character code, digits out of radix.
	task automatic test_bad_characters();
		send_string("0X");
		send_string("--");
		send_char(8'hFF, 1'b1);
		send_string("0b2");
		send_string("0xg");
		wait_drain();
	endtask

	// Build one token, mostly well formed, sometimes broken, and send it.
	task automatic send_random_token();
		logic [7:0] chars[$];
		int         radix_pick;
		int         digit_count;
		int         pick;
		int         ending;
		logic [7:0] terms[5];
		terms = '{CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
		// Drop some noise between tokens, and now and then a lone random start.
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 3))
				send_char(8'($urandom_range(255)), 1'b0);
		if ($urandom_range(19) == 0)
			send_char(8'($urandom_range(255)), 1'b1);
		if ($urandom_range(3) == 0)
			chars.push_back(CH_MINUS);
		radix_pick = $urandom_range(2);
		if (radix_pick != 0) begin
			chars.push_back(CH_ZERO);
			chars.push_back(radix_pick == 1 ? CH_LC_B : CH_LC_X);
			if (chars[0] != CH_MINUS && $urandom_range(3) == 0)
				chars.push_back(CH_MINUS);
		end
		// Mostly short numbers; some long enough to wrap.
		digit_count = ($urandom_range(8) == 0) ? $urandom_range(10, 40) : $urandom_range(8);
		repeat (digit_count) begin
			case (radix_pick)
				1: chars.push_back(CH_ZERO + 8'($urandom_range(1)));
				2: begin
					pick = $urandom_range(21);
					if (pick < 10)
						chars.push_back(CH_ZERO + 8'(pick));
					else if (pick < 16)
						chars.push_back(CH_UC_A + 8'(pick - 10));
					else
						chars.push_back(CH_LC_A + 8'(pick - 16));
				end
				default: chars.push_back(CH_ZERO + 8'($urandom_range(9)));
			endcase
		end
		ending = $urandom_range(99);
		if (ending < 80)
			chars.push_back(terms[$urandom_range(4)]);
		else if (ending < 88)
			chars.push_back(8'($urandom_range(255)));
		else if (ending < 93)
			chars.push_back(CH_MINUS);
		else if (ending < 97)
			; // leave the token open; the next start cuts it off
		else
			chars.push_back($urandom_range(1) ? "X" : "B");
		foreach (chars[i])
			send_char(chars[i], i == 0);
		token_chars += chars.size();
	endtask

	task automatic test_random_stream(input int char_goal, input int gap_pct, input int stall_pct);
		int first;
		first          = token_chars;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		while (token_chars - first < char_goal)
			send_random_token();
		wait_drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		acc_value  = '0;
		minus_seen = 1'b0;
		cur_radix  = RADIX_DEC;
		cur_phase  = PH_IDLE;

		test_ignored_and_restart();
		test_empty_tokens();
		test_prefixes_and_signs();
		test_bad_characters();

		// Idling phases: none, sender gaps, receiver stalls, both light.
		test_random_stream(175, 0, 0);
		test_random_stream(175, 60, 0);
		test_random_stream(175, 0, 60);
		test_random_stream(175, 9, 9);

		// Let the result register settle before the verdict.
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
